// ===== src/vertex_rotate_project_assert.svh =====
// Assertion macros for the vertex rotate / project block.
`ifndef VERTEX_ROTATE_PROJECT_ASSERT_SVH
`define VERTEX_ROTATE_PROJECT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define VRP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define VRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/vrp_pkg.sv =====
package vrp_pkg;

   parameter int COORD_W  = 16;
   parameter int COEF_W   = 16;
   parameter int CENTER_W = 14;
   parameter int SCREEN_W = 17;

   parameter int SCREEN_MAX = 65535;
   parameter int SCREEN_MIN = -65536;

   // Register map
   typedef enum logic [2:0] {
      CSR_COS_AZIMUTH   = 3'd0,
      CSR_SIN_AZIMUTH   = 3'd1,
      CSR_COS_ELEVATION = 3'd2,
      CSR_SIN_ELEVATION = 3'd3,
      CSR_PIXEL_SCALE   = 3'd4,
      CSR_CENTER_X      = 3'd5,
      CSR_CENTER_Y      = 3'd6
   } csr_index_type;

   parameter int CSR_INDEX_W = 3;
   parameter int CSR_DATA_W  = 16;

endpackage

// ===== src/vertex_rotate_project.sv =====
// Vertex rotation (Y then X axis) and perspective projection to screen pixels.
// Pipeline: 34 register stages. Throughput: one vertex per cycle while the output
// is not stalled; the 25-step restoring divider for 3/(z'+2.5) is fully pipelined,
// one quotient bit per stage. An output stall freezes the pipe.
// Reset (synchronous): clears all stage valids, loads register reset values
// (identity rotation, pixel_scale 256.0, center 0,0).
module vertex_rotate_project (
   input  logic                                    clock,
   input  logic                                    reset,
   // vertex channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [vrp_pkg::COORD_W-1:0]      req_vert_x,
   input  logic signed [vrp_pkg::COORD_W-1:0]      req_vert_y,
   input  logic signed [vrp_pkg::COORD_W-1:0]      req_vert_z,
   // screen point channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [vrp_pkg::SCREEN_W-1:0]     rsp_screen_x,
   output logic signed [vrp_pkg::SCREEN_W-1:0]     rsp_screen_y,
   // register write channel
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic        [vrp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic        [vrp_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int DIV_STEPS = 25;          // quotient bits of d (Q9.16)
   localparam int DV_W      = 19;          // divisor z'+2.5, known positive
   localparam int NUM_W     = 30;          // 3*2^28 + dz/2
   localparam int ROT1_W    = 19;          // x1, z1
   localparam int ROT2_W    = 20;          // y2, dz
   localparam int P_W       = 36;          // coord * pixel_scale
   localparam int LO_W      = 13;          // low part of d
   localparam int HI_W      = DIV_STEPS - LO_W;
   localparam int T_W       = 62;          // coord * scale * d plus rounding
   localparam int OFF_W     = 29;
   localparam int SUM_W     = 30;

   localparam logic signed [32:0] RND14_33   = 33'sd8192;
   localparam logic signed [35:0] RND14_36   = 36'sd8192;
   localparam logic signed [35:0] DZ_BIAS    = 36'sd167772160;   // 2.5 in Q.26
   localparam logic signed [ROT2_W-1:0] DZ_MIN = 20'sd40;
   localparam logic [NUM_W-1:0]     NUM_BASE  = 30'd805306368;   // 3 << 28
   localparam logic [DIV_STEPS-1:0] D_FALLBACK = 25'd66;         // 0.001 in Q9.16
   localparam logic signed [T_W-1:0] RND32    = 62'sd2147483648;

   typedef struct packed {
      logic [DV_W-1:0]          rem;
      logic [DIV_STEPS-1:0]     nq;    // dividend bits shift out, quotient bits shift in
      logic [DV_W-1:0]          dv;
      logic                     fallback;
      logic signed [P_W-1:0]    px;
      logic signed [P_W-1:0]    py;
   } div_stage_type;

   // ---------------- configuration registers ----------------
   logic signed [vrp_pkg::COEF_W-1:0] cos_az_ff, sin_az_ff, cos_el_ff, sin_el_ff;
   logic [vrp_pkg::COEF_W-1:0]        pixel_scale_ff;
   logic [vrp_pkg::CENTER_W-1:0]      center_x_ff, center_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_az_ff      <= 16'sd16384;
         sin_az_ff      <= 16'sd0;
         cos_el_ff      <= 16'sd16384;
         sin_el_ff      <= 16'sd0;
         pixel_scale_ff <= 16'd4096;
         center_x_ff    <= '0;
         center_y_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (vrp_pkg::csr_index_type'(csr_index))
            vrp_pkg::CSR_COS_AZIMUTH:   cos_az_ff      <= csr_data;
            vrp_pkg::CSR_SIN_AZIMUTH:   sin_az_ff      <= csr_data;
            vrp_pkg::CSR_COS_ELEVATION: cos_el_ff      <= csr_data;
            vrp_pkg::CSR_SIN_ELEVATION: sin_el_ff      <= csr_data;
            vrp_pkg::CSR_PIXEL_SCALE:   pixel_scale_ff <= csr_data;
            vrp_pkg::CSR_CENTER_X:      center_x_ff    <= csr_data[vrp_pkg::CENTER_W-1:0];
            vrp_pkg::CSR_CENTER_Y:      center_y_ff    <= csr_data[vrp_pkg::CENTER_W-1:0];
            default: ;
         endcase
      end
   end

   logic signed [vrp_pkg::COEF_W:0] scale_s;
   assign scale_s = $signed({1'b0, pixel_scale_ff});

   // ---------------- pipeline control ----------------
   logic en;
   logic out_valid_ff;
   assign en        = !out_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // stage valids
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, vg_ff, vh_ff;
   logic div_v_ff [0:DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         vg_ff        <= 1'b0;
         vh_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k <= DIV_STEPS; k++) div_v_ff[k] <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         div_v_ff[0]  <= v5_ff;
         for (int k = 1; k <= DIV_STEPS; k++) div_v_ff[k] <= div_v_ff[k-1];
         vg_ff        <= div_v_ff[DIV_STEPS];
         vh_ff        <= vg_ff;
         out_valid_ff <= vh_ff;
      end
   end

   // ---------------- stage 1: input beat ----------------
   logic signed [vrp_pkg::COORD_W-1:0] vx1_ff, vy1_ff, vz1_ff;

   // ---------------- stage 2: azimuth products ----------------
   logic signed [31:0] p_cx_ff, p_sz_ff, p_cz_ff, p_sx_ff;
   logic signed [vrp_pkg::COORD_W-1:0] vy2_ff;

   // ---------------- stage 3: x1, z1 ----------------
   logic signed [32:0] x1_sum, z1_sum;
   logic signed [ROT1_W-1:0] x1_ff, z1_ff;
   logic signed [vrp_pkg::COORD_W-1:0] vy3_ff;

   assign x1_sum = 33'(p_cx_ff) + 33'(p_sz_ff) + RND14_33;
   assign z1_sum = 33'(p_cz_ff) - 33'(p_sx_ff) + RND14_33;

   // ---------------- stage 4: elevation products, x1*scale ----------------
   logic signed [31:0] p_cy_ff, p_sy_ff;
   logic signed [34:0] p_sz1_ff, p_cz1_ff;
   logic signed [P_W-1:0] px4_ff;

   // ---------------- stage 5: y2, dz ----------------
   logic signed [35:0] y2_sum, dz_sum;
   logic signed [ROT2_W-1:0] y2_ff, dz_ff;
   logic signed [P_W-1:0] px5_ff;

   // z'+2.5 folded into the rounding add: the bias is a multiple of 2^14
   assign y2_sum = 36'(p_cy_ff) - 36'(p_sz1_ff) + RND14_36;
   assign dz_sum = 36'(p_sy_ff) + 36'(p_cz1_ff) + RND14_36 + DZ_BIAS;

   always_ff @(posedge clock) begin
      if (en) begin
         vx1_ff   <= req_vert_x;
         vy1_ff   <= req_vert_y;
         vz1_ff   <= req_vert_z;

         p_cx_ff  <= cos_az_ff * vx1_ff;
         p_sz_ff  <= sin_az_ff * vz1_ff;
         p_cz_ff  <= cos_az_ff * vz1_ff;
         p_sx_ff  <= sin_az_ff * vx1_ff;
         vy2_ff   <= vy1_ff;

         x1_ff    <= x1_sum[32:14];
         z1_ff    <= z1_sum[32:14];
         vy3_ff   <= vy2_ff;

         p_cy_ff  <= cos_el_ff * vy3_ff;
         p_sy_ff  <= sin_el_ff * vy3_ff;
         p_sz1_ff <= sin_el_ff * z1_ff;
         p_cz1_ff <= cos_el_ff * z1_ff;
         px4_ff   <= x1_ff * scale_s;

         y2_ff    <= y2_sum[33:14];
         dz_ff    <= dz_sum[33:14];
         px5_ff   <= px4_ff;
      end
   end

   // ---------------- divider: d = (3*2^28 + dz/2) / dz ----------------
   div_stage_type div_ff [0:DIV_STEPS];
   div_stage_type div_in [0:DIV_STEPS];

   logic signed [P_W:0]    py_full;
   logic                   dz_ok;
   logic [NUM_W-1:0]       num;
   logic [DV_W:0]          trial [1:DIV_STEPS];
   logic [DV_W:0]          diff  [1:DIV_STEPS];

   assign py_full = y2_ff * scale_s;
   assign dz_ok   = dz_ff > DZ_MIN;
   assign num     = NUM_BASE + NUM_W'(dz_ff[DV_W-1:1]);

   always_comb begin
      div_in[0].rem      = DV_W'(num[NUM_W-1:DIV_STEPS]);
      div_in[0].nq       = num[DIV_STEPS-1:0];
      // divisor of one keeps the fallback lanes harmless; their quotient is dropped
      div_in[0].dv       = dz_ok ? dz_ff[DV_W-1:0] : DV_W'(1);
      div_in[0].fallback = !dz_ok;
      div_in[0].px       = px5_ff;
      div_in[0].py       = py_full[P_W-1:0];
      for (int k = 1; k <= DIV_STEPS; k++) begin
         trial[k]  = {div_ff[k-1].rem, div_ff[k-1].nq[DIV_STEPS-1]};
         diff[k]   = trial[k] - {1'b0, div_ff[k-1].dv};
         div_in[k] = div_ff[k-1];
         if (trial[k] >= {1'b0, div_ff[k-1].dv}) begin
            div_in[k].rem = diff[k][DV_W-1:0];
            div_in[k].nq  = {div_ff[k-1].nq[DIV_STEPS-2:0], 1'b1};
         end else begin
            div_in[k].rem = trial[k][DV_W-1:0];
            div_in[k].nq  = {div_ff[k-1].nq[DIV_STEPS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= DIV_STEPS; k++) div_ff[k] <= div_in[k];
      end
   end

   // ---------------- stage g: split products with d ----------------
   logic [DIV_STEPS-1:0]       d_val;
   logic signed [LO_W:0]       d_lo;
   logic signed [HI_W:0]       d_hi;
   logic signed [P_W+LO_W:0]   pxl_ff, pyl_ff;
   logic signed [P_W+HI_W:0]   pxh_ff, pyh_ff;

   assign d_val = div_ff[DIV_STEPS].fallback ? D_FALLBACK : div_ff[DIV_STEPS].nq;
   assign d_lo  = $signed({1'b0, d_val[LO_W-1:0]});
   assign d_hi  = $signed({1'b0, d_val[DIV_STEPS-1:LO_W]});

   // ---------------- stage h: recombine, round to pixels ----------------
   logic signed [T_W-1:0]   tx, ty;
   logic signed [OFF_W-1:0] offx_ff, offy_ff;

   assign tx = (T_W'(pxh_ff) <<< LO_W) + T_W'(pxl_ff) + RND32;
   assign ty = (T_W'(pyh_ff) <<< LO_W) + T_W'(pyl_ff) + RND32;

   // ---------------- output stage: center and saturate ----------------
   logic signed [SUM_W-1:0] sx_sum, sy_sum;
   logic signed [vrp_pkg::SCREEN_W-1:0] sx_sat, sy_sat, sx_ff, sy_ff;

   assign sx_sum = $signed({{(SUM_W-vrp_pkg::CENTER_W){1'b0}}, center_x_ff}) + SUM_W'(offx_ff);
   assign sy_sum = $signed({{(SUM_W-vrp_pkg::CENTER_W){1'b0}}, center_y_ff}) - SUM_W'(offy_ff);

   always_comb begin
      priority if (sx_sum > SUM_W'(vrp_pkg::SCREEN_MAX))
         sx_sat = vrp_pkg::SCREEN_W'(vrp_pkg::SCREEN_MAX);
      else if (sx_sum < SUM_W'(vrp_pkg::SCREEN_MIN))
         sx_sat = vrp_pkg::SCREEN_W'(vrp_pkg::SCREEN_MIN);
      else
         sx_sat = sx_sum[vrp_pkg::SCREEN_W-1:0];

      priority if (sy_sum > SUM_W'(vrp_pkg::SCREEN_MAX))
         sy_sat = vrp_pkg::SCREEN_W'(vrp_pkg::SCREEN_MAX);
      else if (sy_sum < SUM_W'(vrp_pkg::SCREEN_MIN))
         sy_sat = vrp_pkg::SCREEN_W'(vrp_pkg::SCREEN_MIN);
      else
         sy_sat = sy_sum[vrp_pkg::SCREEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pxl_ff  <= div_ff[DIV_STEPS].px * d_lo;
         pxh_ff  <= div_ff[DIV_STEPS].px * d_hi;
         pyl_ff  <= div_ff[DIV_STEPS].py * d_lo;
         pyh_ff  <= div_ff[DIV_STEPS].py * d_hi;

         offx_ff <= tx[OFF_W+31:32];
         offy_ff <= ty[OFF_W+31:32];

         sx_ff   <= sx_sat;
         sy_ff   <= sy_sat;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_screen_x = sx_ff;
   assign rsp_screen_y = sy_ff;

endmodule

// ===== src/vrp_checker.sv =====
`include "vertex_rotate_project_assert.svh"

module vrp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [vrp_pkg::SCREEN_W-1:0] rsp_screen_x,
   input logic signed [vrp_pkg::SCREEN_W-1:0] rsp_screen_y
);

   // a held result beat keeps its payload
   `VRP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_screen_x) && $stable(rsp_screen_y), "rsp beat changed while stalled")

   // empty output never backs up the input
   `VRP_ASSERT_SAME(a_no_idle_stall, clock, reset, !rsp_valid, !req_stall, "req stalled with empty output")

   // an output stall is passed back to the input
   `VRP_ASSERT_SAME(a_stall_through, clock, reset, rsp_valid && rsp_stall, req_stall, "output stall not passed to input")

   `VRP_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "rsp_valid high after reset")

endmodule

bind vertex_rotate_project vrp_checker u_vrp_checker (.*);
